>>> src/open_addressing_page_map_macros.svh
// assertion macros for the open addressing page map
`ifndef OPEN_ADDRESSING_PAGE_MAP_MACROS_SVH
`define OPEN_ADDRESSING_PAGE_MAP_MACROS_SVH

// same-cycle implication, checked out of reset
`define OAPM_CHECK(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("oapm check failed");

// next-cycle implication, checked out of reset
`define OAPM_CHECK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("oapm check failed");

`endif

>>> src/oapm_pkg.sv
// types and constants shared by the page map
package oapm_pkg;

    // request kinds
    typedef enum logic [1:0] {
        K_INSERT    = 2'd0,
        K_REMOVE    = 2'd1,
        K_LOOKUP    = 2'd2,
        K_LOOKUP_GEN = 2'd3
    } t_kind;

    // slot status codes
    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_LIVE  = 2'd1,
        ST_TOMB  = 2'd2
    } t_slot_st;

    // stored slot record
    typedef struct packed {
        logic [31:0] key_x;
        logic [31:0] key_y;
        logic [31:0] key_z;
        logic [31:0] page;
        logic [31:0] generation;
        logic [31:0] flags;
        logic [63:0] occupancy;
    } t_slot_rec;

    localparam logic [31:0] EMPTY_MARK     = 32'hFFFF_FFFF;
    localparam logic [31:0] TOMBSTONE_MARK = 32'hFFFF_FFFE;
    localparam int unsigned CAP_LOG_MAX    = 10;
    localparam int unsigned CW             = 11;
    localparam int unsigned FW             = 17;
    localparam logic [FW-1:0] FILL_SCALE   = 17'd100;
    localparam logic [FW-1:0] FILL_LIMIT   = 17'd71;

endpackage

>>> src/open_addressing_page_map.sv
// open addressing page map: linear probing table with tombstones
// a rejected insert is answered straight from idle; any other request probes slot by slot,
//   each probe passing a read and an evaluate state; one request at a time, busy stays high meanwhile
// the slot memory reads one slot per probe step
// reset and every capacity write run a clearing pass over all MAX_SLOTS slots (busy high)
// each result is shown for one cycle on o_valid; the receiver cannot stall
`include "open_addressing_page_map_macros.svh"

module open_addressing_page_map
    import oapm_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic [31:0]        i_page_number,
    input  logic [31:0]        i_generation_in,
    input  logic [31:0]        i_flag_bits,
    input  logic [31:0]        i_occupancy_low,
    input  logic [31:0]        i_occupancy_high,
    output logic               o_valid,
    output logic               o_ok,
    output logic [31:0]        o_found_page,
    output logic [31:0]        o_found_flags,
    output logic [31:0]        o_found_generation
);

    localparam int unsigned AW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned LOG_FIT = $clog2(MAX_SLOTS + 1) - 1;
    localparam int unsigned LOG_TOP = (LOG_FIT < CAP_LOG_MAX) ? LOG_FIT : CAP_LOG_MAX;
    localparam logic [3:0]  LOG_TOP_V = 4'(LOG_TOP);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SLOTS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    t_state          r_state;
    logic [3:0]      r_cap;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_clr;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_live;
    logic            r_tomb_valid;
    logic [AW-1:0]   r_tomb;
    t_kind           r_kind;
    t_slot_rec       r_req;

    // slot memories
    t_slot_st        st_mem [MAX_SLOTS];
    t_slot_rec       rec_mem [MAX_SLOTS];
    t_slot_st        r_st_rd;
    t_slot_rec       r_rec_rd;

    logic [CW-1:0]   slots;
    logic [AW-1:0]   mask;
    logic [31:0]     hash_w;
    logic [AW-1:0]   start_slot;
    logic            cfg_wr;
    logic [3:0]      cap_clamped;

    // capacity writes only while idle and no request is offered
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign busy        = (r_state != S_IDLE);
    assign slots       = CW'(1) << r_cap;
    assign mask        = AW'(slots - CW'(1));

    // clamp the written capacity into range
    always_comb begin
        cap_clamped = i_cfg_data;
        if (cap_clamped < 4'd1) begin
            cap_clamped = 4'd1;
        end
        if (cap_clamped > LOG_TOP_V) begin
            cap_clamped = LOG_TOP_V;
        end
    end

    // fixed fold hash of the key
    always_comb begin
        hash_w = i_coord_x ^ {i_coord_y[15:0], i_coord_y[31:16]} ^ (i_coord_z * 32'h0000_0007);
        hash_w = hash_w ^ (hash_w >> 16);
    end
    assign start_slot = AW'(hash_w) & mask;

    // probe evaluation
    logic            key_match;
    logic            last_probe;
    logic            fill_ok;
    logic            cand_valid;
    logic [AW-1:0]   cand;
    logic [FW-1:0]   fill_num;
    logic [FW-1:0]   fill_cap;
    logic            e_done;
    logic            e_ok;
    logic            e_found;
    logic            e_wr;
    logic            e_wr_rec;
    logic [AW-1:0]   e_wr_addr;
    t_slot_st        e_wr_st;
    logic            e_inc;
    logic            e_dec;
    logic            e_set_tomb;

    assign key_match = (r_st_rd == ST_LIVE) && (r_rec_rd.key_x == r_req.key_x)
                       && (r_rec_rd.key_y == r_req.key_y) && (r_rec_rd.key_z == r_req.key_z);
    assign last_probe = ((r_cnt + CW'(1)) == slots);
    assign fill_num   = FW'(r_live + CW'(1)) * FILL_SCALE;
    assign fill_cap   = FW'(slots) * FILL_LIMIT;
    assign fill_ok    = (fill_num < fill_cap);
    assign cand_valid = r_tomb_valid || (r_st_rd == ST_TOMB);
    assign cand       = r_tomb_valid ? r_tomb : r_addr;

    always_comb begin
        e_done     = 1'b0;
        e_ok       = 1'b0;
        e_found    = 1'b0;
        e_wr       = 1'b0;
        e_wr_rec   = 1'b0;
        e_wr_addr  = r_addr;
        e_wr_st    = ST_LIVE;
        e_inc      = 1'b0;
        e_dec      = 1'b0;
        e_set_tomb = 1'b0;
        if (r_kind == K_INSERT) begin
            if (key_match) begin
                e_done   = 1'b1;
                e_ok     = 1'b1;
                e_wr     = 1'b1;
                e_wr_rec = 1'b1;
            end else if (r_st_rd == ST_EMPTY) begin
                e_done    = 1'b1;
                e_wr_addr = r_tomb_valid ? r_tomb : r_addr;
                if (fill_ok) begin
                    e_ok     = 1'b1;
                    e_wr     = 1'b1;
                    e_wr_rec = 1'b1;
                    e_inc    = 1'b1;
                end
            end else if (last_probe) begin
                e_done    = 1'b1;
                e_wr_addr = cand;
                if (cand_valid && fill_ok) begin
                    e_ok     = 1'b1;
                    e_wr     = 1'b1;
                    e_wr_rec = 1'b1;
                    e_inc    = 1'b1;
                end
            end else begin
                e_set_tomb = (r_st_rd == ST_TOMB) && !r_tomb_valid;
            end
        end else begin
            if (key_match) begin
                e_done = 1'b1;
                if (r_kind == K_REMOVE) begin
                    e_ok    = 1'b1;
                    e_wr    = 1'b1;
                    e_wr_st = ST_TOMB;
                    e_dec   = (r_live != '0);
                end else begin
                    e_found = 1'b1;
                    e_ok    = (r_kind == K_LOOKUP) || (r_rec_rd.generation == r_req.generation);
                end
            end else if ((r_st_rd == ST_EMPTY) || last_probe) begin
                e_done = 1'b1;
            end
        end
    end

    // memory write port: clearing sweep or probe result
    logic            m_wr;
    logic [AW-1:0]   m_addr;
    t_slot_st        m_st;

    always_comb begin
        m_wr   = 1'b0;
        m_addr = r_clr;
        m_st   = ST_EMPTY;
        if (r_state == S_CLEAR) begin
            m_wr = 1'b1;
        end else if (r_state == S_EVAL) begin
            m_wr   = e_wr;
            m_addr = e_wr_addr;
            m_st   = e_wr_st;
        end
    end

    // status memory
    always_ff @(posedge i_clk) begin
        if (m_wr) begin
            st_mem[m_addr] <= m_st;
        end
        r_st_rd <= st_mem[r_addr];
    end

    // record memory
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EVAL) && e_wr_rec) begin
            rec_mem[e_wr_addr] <= r_req;
        end
        r_rec_rd <= rec_mem[r_addr];
    end

    // sequencer, counters and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cap        <= LOG_TOP_V;
            r_clr        <= '0;
            r_cnt        <= '0;
            r_live       <= '0;
            r_tomb_valid <= 1'b0;
            r_addr       <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (cfg_wr) begin
                r_cap   <= cap_clamped;
                r_clr   <= '0;
                r_live  <= '0;
                r_state <= S_CLEAR;
            end else begin
                case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + AW'(1);
                        if (r_clr == CLR_LAST) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (start) begin
                            r_kind       <= t_kind'(i_kind);
                            r_req        <= '{key_x: i_coord_x, key_y: i_coord_y,
                                              key_z: i_coord_z, page: i_page_number,
                                              generation: i_generation_in, flags: i_flag_bits,
                                              occupancy: {i_occupancy_high, i_occupancy_low}};
                            r_addr       <= start_slot;
                            r_cnt        <= '0;
                            r_tomb_valid <= 1'b0;
                            if ((t_kind'(i_kind) == K_INSERT) && ((i_page_number == EMPTY_MARK)
                                || (i_page_number == TOMBSTONE_MARK) || (i_generation_in == '0))) begin
                                o_valid            <= 1'b1;
                                o_ok               <= 1'b0;
                                o_found_page       <= '0;
                                o_found_flags      <= '0;
                                o_found_generation <= '0;
                            end else begin
                                r_state <= S_READ;
                            end
                        end
                    end
                    S_READ: begin
                        r_state <= S_EVAL;
                    end
                    S_EVAL: begin
                        if (e_set_tomb) begin
                            r_tomb_valid <= 1'b1;
                            r_tomb       <= r_addr;
                        end
                        if (e_done) begin
                            r_state            <= S_IDLE;
                            o_valid            <= 1'b1;
                            o_ok               <= e_ok;
                            o_found_page       <= e_found ? r_rec_rd.page : '0;
                            o_found_flags      <= e_found ? r_rec_rd.flags : '0;
                            o_found_generation <= e_found ? r_rec_rd.generation : '0;
                            if (e_inc) begin
                                r_live <= r_live + CW'(1);
                            end else if (e_dec) begin
                                r_live <= r_live - CW'(1);
                            end
                        end else begin
                            r_cnt   <= r_cnt + CW'(1);
                            r_addr  <= (r_addr + AW'(1)) & mask;
                            r_state <= S_READ;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // checks
    `OAPM_CHECK(a_result_when_idle, o_valid, !busy)
    `OAPM_CHECK(a_live_below_slots, 1'b1, r_live < slots)
    `OAPM_CHECK_NEXT(a_accept_progress, start && !busy, busy || o_valid)
    `OAPM_CHECK_NEXT(a_cfg_clears, cfg_wr, (r_state == S_CLEAR) && (r_live == '0) && !o_valid)

endmodule

>>> bench/open_addressing_page_map_tb.sv
// testbench for the open addressing page map: scoreboard class and request drivers
`timescale 1ns / 1ps

module open_addressing_page_map_tb;
    import oapm_pkg::*;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned ITEMS_PER_PHASE = 85;
    localparam int unsigned POOL_SIZE = 40;

    // stored record of one live key
    typedef struct {
        bit [31:0] page;
        bit [31:0] generation;
        bit [31:0] flags;
    } page_rec_t;

    // one expected response
    typedef struct {
        bit        ok;
        bit [31:0] page;
        bit [31:0] flags;
        bit [31:0] generation;
    } map_reply_t;

    // abstract map model: live keys only, so the hash never matters
    class page_map_scoreboard;
        page_rec_t   live_keys[bit [95:0]];
        int unsigned slot_total;
        map_reply_t  pending[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned fill_rejects;

        function void set_capacity(bit [3:0] value);
            int unsigned lg;
            lg = value;
            if (lg < 1) lg = 1;
            if (lg > CAP_LOG_MAX) lg = CAP_LOG_MAX;
            slot_total = 1 << lg;
            live_keys.delete();
        endfunction

        function void note_request(t_kind kind, bit [95:0] key, bit [31:0] page,
                                   bit [31:0] generation, bit [31:0] flags);
            map_reply_t r;
            r = '{default: 0};
            case (kind)
                K_INSERT: begin
                    if (page != EMPTY_MARK && page != TOMBSTONE_MARK && generation != 0) begin
                        if (live_keys.exists(key)) begin
                            live_keys[key] = '{page, generation, flags};
                            r.ok = 1;
                        end else if ((live_keys.num() + 1) * 100 / slot_total > 70) begin
                            fill_rejects++;
                        end else begin
                            live_keys[key] = '{page, generation, flags};
                            r.ok = 1;
                        end
                    end
                end
                K_REMOVE: begin
                    if (live_keys.exists(key)) begin
                        live_keys.delete(key);
                        r.ok = 1;
                    end
                end
                default: begin
                    if (live_keys.exists(key)) begin
                        r.page = live_keys[key].page;
                        r.flags = live_keys[key].flags;
                        r.generation = live_keys[key].generation;
                        r.ok = (kind == K_LOOKUP) || (r.generation == generation);
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(bit ok, bit [31:0] page, bit [31:0] flags,
                                   bit [31:0] generation);
            map_reply_t r;
            if (pending.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            r = pending.pop_front();
            checked++;
            if (ok != r.ok) begin
                $error("ok: expected %0d, actual %0d", r.ok, ok);
                errors++;
            end
            if (page != r.page) begin
                $error("found_page: expected %h, actual %h", r.page, page);
                errors++;
            end
            if (flags != r.flags) begin
                $error("found_flags: expected %h, actual %h", r.flags, flags);
                errors++;
            end
            if (generation != r.generation) begin
                $error("found_generation: expected %h, actual %h", r.generation, generation);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_data;
    logic               start;
    logic               busy;
    logic [1:0]         i_kind;
    logic signed [31:0] i_coord_x;
    logic signed [31:0] i_coord_y;
    logic signed [31:0] i_coord_z;
    logic [31:0]        i_page_number;
    logic [31:0]        i_generation_in;
    logic [31:0]        i_flag_bits;
    logic [31:0]        i_occupancy_low;
    logic [31:0]        i_occupancy_high;
    logic               o_valid;
    logic               o_ok;
    logic [31:0]        o_found_page;
    logic [31:0]        o_found_flags;
    logic [31:0]        o_found_generation;

    page_map_scoreboard sb;
    bit [95:0]          key_pool[POOL_SIZE];
    bit                 calm;
    int unsigned        stall_count;

    open_addressing_page_map DUT (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_ok, o_found_page, o_found_flags, o_found_generation);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // present one request and hold it until accepted
    task automatic send_request(t_kind kind, bit [95:0] key, bit [31:0] page,
                                bit [31:0] generation, bit [31:0] flags,
                                bit [31:0] occ_lo, bit [31:0] occ_hi);
        start <= 1'b1;
        i_kind <= kind;
        i_coord_x <= key[95:64];
        i_coord_y <= key[63:32];
        i_coord_z <= key[31:0];
        i_page_number <= page;
        i_generation_in <= generation;
        i_flag_bits <= flags;
        i_occupancy_low <= occ_lo;
        i_occupancy_high <= occ_hi;
        do @(posedge i_clk); while (busy);
        sb.note_request(kind, key, page, generation, flags);
    endtask

    // sender gap
    task automatic pause_sender(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // maybe insert a short idle burst
    task automatic random_gap();
        if (!calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 3));
    endtask

    // wait until every expected response has come, at least one idle cycle
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    // capacity write while idle, then wait out the clearing pass
    task automatic write_capacity(bit [3:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_capacity(value);
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // random request mostly over a small key pool
    task automatic random_request();
        t_kind     kind;
        bit [95:0] key;
        bit [31:0] page;
        bit [31:0] generation;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        kind = pick < 4 ? K_INSERT : pick < 6 ? K_REMOVE : pick < 8 ? K_LOOKUP : K_LOOKUP_GEN;
        if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom, $urandom};
        else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        pick = $urandom_range(0, 19);
        page = pick == 0 ? EMPTY_MARK : pick == 1 ? TOMBSTONE_MARK : $urandom;
        generation = $urandom_range(0, 19) == 0 ? 32'd0 : $urandom;
        if (kind == K_LOOKUP_GEN && sb.live_keys.exists(key) && $urandom_range(0, 1))
            generation = sb.live_keys[key].generation;
        send_request(kind, key, page, generation, $urandom, $urandom, $urandom);
        random_gap();
    endtask

    initial begin
        bit [3:0]  caps[8];
        bit [95:0] ka;
        bit [95:0] kb;
        caps = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd2, 4'd6, 4'd10, 4'd4};
        sb = new();
        sb.set_capacity(4'd10);
        calm = 0;
        stall_count = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        start = 1'b0;
        i_kind = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_page_number = '0;
        i_generation_in = '0;
        i_flag_bits = '0;
        i_occupancy_low = '0;
        i_occupancy_high = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // directed: field extremes, reserved pages, zero generation, reuse after removal
        ka = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
        kb = {32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        send_request(K_LOOKUP, ka, 0, 0, 0, 0, 0);
        send_request(K_INSERT, ka, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0);
        send_request(K_INSERT, kb, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(K_INSERT, ka, EMPTY_MARK, 32'h5, 32'h1, 32'h2, 32'h3);
        send_request(K_INSERT, kb, TOMBSTONE_MARK, 32'h5, 32'h1, 32'h2, 32'h3);
        send_request(K_INSERT, ka, 32'h1234, 32'h0, 32'h1, 32'h2, 32'h3);
        send_request(K_LOOKUP, ka, 0, 0, 0, 0, 0);
        send_request(K_LOOKUP_GEN, kb, 0, 32'hFFFF_FFFF, 0, 0, 0);
        send_request(K_LOOKUP_GEN, kb, 0, 32'h7, 0, 0, 0);
        send_request(K_INSERT, ka, 32'hABCD, 32'h9, 32'h5A5A_A5A5, 32'h1, 32'h2);
        send_request(K_LOOKUP_GEN, ka, 0, 32'h9, 0, 0, 0);
        send_request(K_REMOVE, ka, 0, 0, 0, 0, 0);
        send_request(K_REMOVE, ka, 0, 0, 0, 0, 0);
        send_request(K_LOOKUP, ka, 0, 0, 0, 0, 0);
        send_request(K_LOOKUP_GEN, ka, 0, 32'h9, 0, 0, 0);
        send_request(K_INSERT, ka, 32'h77, 32'h3, 32'h4, 32'h5, 32'h6);
        send_request(K_LOOKUP, ka, 0, 0, 0, 0, 0);
        send_request(K_LOOKUP, kb, 0, 0, 0, 0, 0);

        // random phases over several capacities, the extremes among them
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom, $urandom};
            calm = (p == 7);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                random_request();
                if (i == ITEMS_PER_PHASE / 2) drain();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d responses never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("checked %0d responses over 9 capacity settings", sb.checked);
        $display("inserts refused at the fill limit: %0d", sb.fill_rejects);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/oapm_pkg.sv
src/open_addressing_page_map.sv
bench/open_addressing_page_map_tb.sv
